// File: hw/rtl/word_punct_utf8_tokenizer_defines.svh
// ---------------------------------------------------------------------------
// Tokenizer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef WORD_PUNCT_UTF8_TOKENIZER_DEFINES_SVH
`define WORD_PUNCT_UTF8_TOKENIZER_DEFINES_SVH

// Same-cycle implication
`define WPT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define WPT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/wpt_pkg.sv
// ---------------------------------------------------------------------------
// wpt_pkg
// Types, constants and codes shared by the tokenizer modules.
// ---------------------------------------------------------------------------
`default_nettype none

package wpt_pkg;

    localparam int MAX_RESULTS = 4;
    localparam int RES_IDX_W   = 2;
    localparam int RES_CNT_W   = 3;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = 2;
    localparam int FIFO_CNT_W  = 3;
    localparam int PADDR_W     = 3;

    // register word index taken from paddr[2]
    localparam logic REG_LANG_MODE = 1'b0;

    localparam logic MODE_WESTERN = 1'b0;
    localparam logic MODE_CHINESE = 1'b1;

    localparam logic [7:0] CH_DOT = 8'h2E;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       text_last;
    } text_req_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       token_end;
        logic       run_last;
    } tok_req_t;

    // one planned result inside a queue entry
    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       fin;
    } res_t;

    // all results caused by one accepted byte
    typedef struct packed {
        logic [RES_CNT_W-1:0]              cnt;
        res_t [MAX_RESULTS-1:0]            res;
    } plan_t;

    typedef struct packed {
        logic       we;
        logic       value;
    } cfg_wr_t;

    typedef struct packed {
        logic       lang_mode;
        logic       in_word;
        logic       dot_held;
        logic [1:0] mb_left;
    } front_status_t;

    typedef struct packed {
        logic empty;
        logic full;
    } fifo_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/wpt_front.sv
// ---------------------------------------------------------------------------
// wpt_front
// Accept text bytes, run the tokenizer state, and push per-byte result plans.
// ---------------------------------------------------------------------------
`default_nettype none

module wpt_front (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire wpt_pkg::cfg_wr_t       cfg,
    input  wire logic                   accept,
    input  wire wpt_pkg::text_req_t     text,
    output wpt_pkg::plan_t              plan,
    output logic                        push,
    output wpt_pkg::front_status_t      status
);

    logic       lang_mode_reg;
    logic       in_word_reg, in_word_next;
    logic       dot_held_reg, dot_held_next;
    logic [1:0] mb_left_reg, mb_left_next;

    logic [7:0] c;
    logic       last;
    logic       is_letter, is_digit, is_space, is_alnum;
    logic [2:0] lead_len;
    logic       mb_fin;
    logic [wpt_pkg::RES_CNT_W-1:0] n;

    assign c         = text.text_byte;
    assign last      = text.text_last;
    assign is_letter = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    assign is_digit  = (c >= 8'h30 && c <= 8'h39);
    assign is_space  = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    assign is_alnum  = is_letter || is_digit;
    assign mb_fin    = (mb_left_reg == 2'd1) || last;

    always_comb
    begin
        if ((c & 8'hE0) == 8'hC0)
            lead_len = 3'd2;
        else if ((c & 8'hF0) == 8'hE0)
            lead_len = 3'd3;
        else if ((c & 8'hF8) == 8'hF0)
            lead_len = 3'd4;
        else
            lead_len = 3'd1;
    end

    always_comb
    begin
        plan          = '0;
        n             = '0;
        in_word_next  = in_word_reg;
        dot_held_next = dot_held_reg;
        mb_left_next  = mb_left_reg;

        if (lang_mode_reg == wpt_pkg::MODE_WESTERN)
        begin
            // resolve a held dot first
            if (dot_held_reg)
            begin
                dot_held_next = 1'b0;
                if (is_letter)
                begin
                    plan.res[n[wpt_pkg::RES_IDX_W-1:0]] = '{wpt_pkg::CH_DOT, 1'b1, 1'b0};
                    n = n + 3'd1;
                end
                else
                begin
                    if (in_word_next)
                    begin
                        plan.res[n[wpt_pkg::RES_IDX_W-1:0]] = '{8'h00, 1'b0, 1'b1};
                        n = n + 3'd1;
                    end
                    in_word_next = 1'b0;
                    plan.res[n[wpt_pkg::RES_IDX_W-1:0]] = '{wpt_pkg::CH_DOT, 1'b1, 1'b1};
                    n = n + 3'd1;
                end
            end
            if (is_alnum || c[7])
            begin
                plan.res[n[wpt_pkg::RES_IDX_W-1:0]] = '{c, 1'b1, last};
                n = n + 3'd1;
                in_word_next = !last;
            end
            else if (c == wpt_pkg::CH_DOT && in_word_next && !last)
            begin
                dot_held_next = 1'b1;
            end
            else
            begin
                if (in_word_next)
                begin
                    plan.res[n[wpt_pkg::RES_IDX_W-1:0]] = '{8'h00, 1'b0, 1'b1};
                    n = n + 3'd1;
                end
                in_word_next = 1'b0;
                if (!is_space)
                begin
                    plan.res[n[wpt_pkg::RES_IDX_W-1:0]] = '{c, 1'b1, 1'b1};
                    n = n + 3'd1;
                end
            end
        end
        else
        begin
            if (mb_left_reg != 2'd0)
            begin
                // continuation bytes are taken whatever their value
                plan.res[0]  = '{c, 1'b1, mb_fin};
                n            = 3'd1;
                mb_left_next = mb_fin ? 2'd0 : mb_left_reg - 2'd1;
            end
            else if (!c[7])
            begin
                if (is_alnum)
                begin
                    plan.res[0]  = '{c, 1'b1, last};
                    n            = 3'd1;
                    in_word_next = !last;
                end
                else
                begin
                    if (in_word_reg)
                    begin
                        plan.res[n[wpt_pkg::RES_IDX_W-1:0]] = '{8'h00, 1'b0, 1'b1};
                        n = n + 3'd1;
                    end
                    in_word_next = 1'b0;
                    if (!is_space)
                    begin
                        plan.res[n[wpt_pkg::RES_IDX_W-1:0]] = '{c, 1'b1, 1'b1};
                        n = n + 3'd1;
                    end
                end
            end
            else
            begin
                if (in_word_reg)
                begin
                    plan.res[n[wpt_pkg::RES_IDX_W-1:0]] = '{8'h00, 1'b0, 1'b1};
                    n = n + 3'd1;
                end
                in_word_next = 1'b0;
                if (lead_len == 3'd1 || last)
                begin
                    plan.res[n[wpt_pkg::RES_IDX_W-1:0]] = '{c, 1'b1, 1'b1};
                    mb_left_next = 2'd0;
                end
                else
                begin
                    plan.res[n[wpt_pkg::RES_IDX_W-1:0]] = '{c, 1'b1, 1'b0};
                    mb_left_next = lead_len[1:0] - 2'd1;
                end
                n = n + 3'd1;
            end
        end

        // text end drops all open state
        if (last)
        begin
            in_word_next  = 1'b0;
            dot_held_next = 1'b0;
            mb_left_next  = 2'd0;
        end
        plan.cnt = n;
    end

    assign push   = accept && (n != '0);
    assign status = '{lang_mode_reg, in_word_reg, dot_held_reg, mb_left_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lang_mode_reg <= wpt_pkg::MODE_WESTERN;
            in_word_reg   <= 1'b0;
            dot_held_reg  <= 1'b0;
            mb_left_reg   <= 2'd0;
        end
        else if (cfg.we)
        begin
            lang_mode_reg <= cfg.value;
            in_word_reg   <= 1'b0;
            dot_held_reg  <= 1'b0;
            mb_left_reg   <= 2'd0;
        end
        else if (accept)
        begin
            in_word_reg   <= in_word_next;
            dot_held_reg  <= dot_held_next;
            mb_left_reg   <= mb_left_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/wpt_fifo.sv
// ---------------------------------------------------------------------------
// wpt_fifo
// Short queue of result plans between the front and the back.
// ---------------------------------------------------------------------------
`default_nettype none

module wpt_fifo (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire wpt_pkg::plan_t         wr_plan,
    input  wire logic                   pop,
    output wpt_pkg::plan_t              head,
    output wpt_pkg::fifo_status_t       status
);

    wpt_pkg::plan_t                     entry_reg [wpt_pkg::FIFO_DEPTH];
    logic [wpt_pkg::FIFO_AW-1:0]        wr_ptr_reg, rd_ptr_reg;
    logic [wpt_pkg::FIFO_CNT_W-1:0]     count_reg;

    assign head         = entry_reg[rd_ptr_reg];
    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == wpt_pkg::FIFO_CNT_W'(wpt_pkg::FIFO_DEPTH));

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= wr_plan;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + wpt_pkg::FIFO_AW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + wpt_pkg::FIFO_AW'(1);
            if (push && !pop)
                count_reg <= count_reg + wpt_pkg::FIFO_CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - wpt_pkg::FIFO_CNT_W'(1);
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/wpt_back.sv
// ---------------------------------------------------------------------------
// wpt_back
// Walk the head plan one result per cycle, while tok_stall is low, into the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module wpt_back (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire wpt_pkg::plan_t         head,
    input  wire wpt_pkg::fifo_status_t  fstat,
    output logic                        pop,
    output logic                        tok_valid,
    input  wire logic                   tok_stall,
    output wpt_pkg::tok_req_t           tok
);

    logic                               out_valid_reg;
    wpt_pkg::tok_req_t                  out_reg;
    logic [wpt_pkg::RES_IDX_W-1:0]      k_reg;
    wpt_pkg::res_t                      cur;
    logic                               load;
    logic                               is_last;

    assign load    = !out_valid_reg || !tok_stall;
    assign cur     = head.res[k_reg];
    assign is_last = ({1'b0, k_reg} + 3'd1) == head.cnt;
    assign pop     = load && !fstat.empty && is_last;

    assign tok_valid = out_valid_reg;
    assign tok       = out_reg;

    always_ff @(posedge clk)
    begin
        if (load && !fstat.empty)
            out_reg <= '{cur.data, cur.has, cur.fin, is_last};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
        end
        else if (load)
        begin
            out_valid_reg <= !fstat.empty;
            if (!fstat.empty)
                k_reg <= is_last ? '0 : k_reg + wpt_pkg::RES_IDX_W'(1);
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/word_punct_utf8_tokenizer.sv
// ---------------------------------------------------------------------------
// word_punct_utf8_tokenizer
// Streaming word/punctuation tokenizer with western and UTF-8 character modes.
// ---------------------------------------------------------------------------
//
//   channel   dir   handshake                 payload
//   text      in    text_valid / text_stall   text_req_t  (text_byte, text_last)
//   tok       out   tok_valid  / tok_stall    tok_req_t   (out_byte, has_byte,
//                                                          token_end, run_last)
//   config    in    APB (psel, penable)       lang_mode at byte address 0
//
// One text byte is accepted per cycle while text_stall is low; the front classifies it in
// that cycle and queues its zero to three results. The back sends one result per cycle
// while tok_stall is low, so a byte with more results takes more output bandwidth; the
// 4-entry queue lets the input keep streaming until that backlog fills it.
// Results go through a queue entry, then the output register. text_stall rises only
// when the queue is full; tok_stall holds the output register and the queue.
// Reset is asynchronous and clears mode, token state, queue and output valid.
//
`default_nettype none
`include "word_punct_utf8_tokenizer_defines.svh"

module word_punct_utf8_tokenizer (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // text request channel
    input  wire logic                           text_valid,
    output logic                                text_stall,
    input  wire wpt_pkg::text_req_t             text,
    // token request channel
    output logic                                tok_valid,
    input  wire logic                           tok_stall,
    output wpt_pkg::tok_req_t                   tok,
    // configuration port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [wpt_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    wpt_pkg::cfg_wr_t       cfg;
    wpt_pkg::front_status_t fr_status;
    wpt_pkg::fifo_status_t  ff_status;
    wpt_pkg::plan_t         plan;
    wpt_pkg::plan_t         head;
    logic                   accept;
    logic                   push;
    logic                   pop;

    // APB decode: zero-wait, register word picked by paddr[2]
    assign pready    = 1'b1;
    assign cfg.we    = psel && penable && pwrite && (paddr[2] == wpt_pkg::REG_LANG_MODE);
    assign cfg.value = pwdata[0];

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == wpt_pkg::REG_LANG_MODE)
            prdata[0] = fr_status.lang_mode;
    end

    // hold input while the plan queue has no room
    assign text_stall = ff_status.full;
    assign accept     = text_valid && !text_stall;

    wpt_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .accept (accept),
        .text   (text),
        .plan   (plan),
        .push   (push),
        .status (fr_status)
    );

    wpt_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_plan (plan),
        .pop     (pop),
        .head    (head),
        .status  (ff_status)
    );

    wpt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .fstat     (ff_status),
        .pop       (pop),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok       (tok)
    );

    // a held dot only exists in western mode inside an open word
    `WPT_ASSERT_NOW(a_dot_in_word, fr_status.dot_held,
        (fr_status.in_word && fr_status.lang_mode == wpt_pkg::MODE_WESTERN),
        "dot held outside a western word")
    // western mode never owes UTF-8 bytes
    `WPT_ASSERT_NOW(a_western_no_mb, (fr_status.lang_mode == wpt_pkg::MODE_WESTERN),
        (fr_status.mb_left == 2'd0), "pending UTF-8 bytes in western mode")
    // text end leaves no open token state
    `WPT_ASSERT_NEXT(a_last_clears, (accept && text.text_last && !cfg.we),
        (!fr_status.in_word && !fr_status.dot_held && fr_status.mb_left == 2'd0),
        "token state survives text end")

endmodule

`default_nettype wire
